// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker in ipid_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge outside reset
`define CHK_ALWAYS(label, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the following cycle
`define CHK_NEXT(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types and constants of the incremental PID controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned PeriodW = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegKp = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKi = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKd = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDt = 2'd3;

  // width of coefficient a, b, c (magnitude below 2^58)
  localparam int unsigned CoefW = 64;
  // accumulator of a*e + b*e1 + c*e2
  localparam int unsigned AccW = 104;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_IMUL,
    ST_COEF,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_FINISH,
    ST_OUT
  } ipid_state_t;

endpackage

// ----- rtl/core/ipid_div.sv -----
// ----------------------------------------------------------------------------
// ipid_div
// Bit-serial restoring divider: quotient = trunc(kd * 2^F / dt), one bit a cycle.
// ----------------------------------------------------------------------------
module ipid_div #(
  parameter int unsigned FRAC_BITS = ipid_pkg::FracBitsDefault
) (
  input  logic                         clk,
  input  logic                         start,
  input  logic signed [ipid_pkg::DataW-1:0]   kd,
  input  logic [ipid_pkg::PeriodW-1:0] dt,
  output logic                         done,
  output logic signed [ipid_pkg::CoefW-1:0]   quot
);
  import ipid_pkg::*;

  localparam int unsigned NumW = DataW + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num;
  logic [PeriodW:0] rem;
  logic [PeriodW-1:0] den;
  logic [CntW-1:0] cnt;
  logic neg;
  logic busy;
  logic [PeriodW+1:0] trial;
  logic [NumW-1:0] mag;
  logic [CoefW-1:0] qext;

  assign mag = kd[DataW-1] ? NumW'(-{{FRAC_BITS{1'b0}}, kd} << FRAC_BITS)
                           : NumW'({{FRAC_BITS{1'b0}}, kd} << FRAC_BITS);
  assign trial = {rem, num[NumW-1]} - {2'b00, den};
  assign qext = CoefW'(num);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      num  <= mag;
      rem  <= '0;
      den  <= (dt == '0) ? PeriodW'(1) : dt;
      neg  <= kd[DataW-1];
      cnt  <= CntW'(NumW);
      busy <= 1'b1;
    end else if (busy) begin
      if (!trial[PeriodW+1]) begin
        rem <= trial[PeriodW:0];
        num <= {num[NumW-2:0], 1'b1};
      end else begin
        rem <= {rem[PeriodW-1:0], num[NumW-1]};
        num <= {num[NumW-2:0], 1'b0};
      end
      cnt <= cnt - CntW'(1);
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = neg ? -$signed(qext) : $signed(qext);
endmodule

// ----- rtl/core/ipid_mul.sv -----
// ----------------------------------------------------------------------------
// ipid_mul
// Serial signed multiplier: 64-bit coefficient times 33-bit operand,
// one multiplier digit of 4 bits a cycle.
// ----------------------------------------------------------------------------
module ipid_mul (
  input  logic                              clk,
  input  logic                              start,
  input  logic signed [ipid_pkg::CoefW-1:0] coef,
  input  logic signed [32:0]                opnd,
  output logic                              done,
  output logic signed [ipid_pkg::AccW-1:0]  prod
);
  import ipid_pkg::*;

  localparam int unsigned DigW = 4;
  localparam int unsigned OpW = 36;
  localparam int unsigned Steps = OpW / DigW;
  localparam int unsigned CntW = $clog2(Steps + 1);

  logic [OpW-1:0] sh;
  logic signed [AccW-1:0] mcand;
  logic [CntW-1:0] cnt;
  logic busy;
  logic signed [AccW-1:0] part;

  // top digit carries the sign weight
  always_comb begin
    if (cnt == CntW'(1)) begin
      part = mcand * $signed({1'b0, sh[DigW-1:0]}) - ((sh[DigW-1]) ? (mcand <<< DigW) : '0);
    end else begin
      part = mcand * $signed({1'b0, sh[DigW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      sh    <= {{(OpW-33){opnd[32]}}, opnd};
      mcand <= AccW'(coef);
      prod  <= '0;
      cnt   <= CntW'(Steps);
      busy  <= 1'b1;
    end else if (busy) begin
      prod  <= prod + part;
      mcand <= mcand <<< DigW;
      sh    <= sh >> DigW;
      cnt   <= cnt - CntW'(1);
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- rtl/core/incremental_pid_controller.sv -----
// From input accept to the result: the one-bit-per-cycle divider for kd/dt, then
// four passes of the 4-bit-per-cycle serial multiplier, plus the coefficient,
// finish and output states. One word at a time: a new word is accepted only
// after the result of the last one is taken, so output stalls hold it off.
// Reset (rst, synchronous): gains zero, sample period 1.0, error history and
// accumulated drive cleared, no result pending.
// ----------------------------------------------------------------------------
// incremental_pid_controller
// Velocity-form PID step with serial divide and serial multiply-accumulate.
// ----------------------------------------------------------------------------
module incremental_pid_controller #(
  parameter int unsigned FRAC_BITS = ipid_pkg::FracBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipid_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [ipid_pkg::DataW-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ipid_pkg::DataW-1:0]   measured,
  input  logic signed [ipid_pkg::DataW-1:0]   setpoint,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ipid_pkg::DataW-1:0]   drive,
  output logic signed [ipid_pkg::DataW-1:0]   increment,
  output logic                                saturated
);
  import ipid_pkg::*;

  localparam logic signed [DataW-1:0] Max32 = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] Min32 = {1'b1, {(DataW-1){1'b0}}};

  ipid_state_t state, state_next;

  logic signed [DataW-1:0] kp, ki, kd;
  logic [PeriodW-1:0] dt;
  logic signed [DataW-1:0] e0, e1, e2, acc;
  logic signed [CoefW-1:0] cq, iterm;
  logic signed [CoefW-1:0] ca, cb;
  logic signed [AccW-1:0] sum;

  logic div_start, div_done;
  logic signed [CoefW-1:0] div_q;
  logic mul_start, mul_done;
  logic signed [CoefW-1:0] mul_coef;
  logic signed [32:0] mul_op;
  logic signed [AccW-1:0] mul_p;

  logic signed [DataW:0] ediff;
  logic signed [DataW-1:0] enew;
  logic signed [AccW-1:0] shifted;
  logic signed [DataW-1:0] inc32;
  logic inc_clip;
  logic signed [DataW:0] dsum;
  logic [PeriodW-1:0] dt_eff;

  assign dt_eff = (dt == '0) ? PeriodW'(1) : dt;
  assign ediff = {setpoint[DataW-1], setpoint} - {measured[DataW-1], measured};
  assign enew = (ediff > $signed({1'b0, Max32})) ? Max32 :
                (ediff < $signed({1'b1, Min32})) ? Min32 : ediff[DataW-1:0];

  assign ca = CoefW'(kp) + iterm + cq;
  assign cb = -CoefW'(kp) + iterm - (cq <<< 1);

  ipid_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .start(div_start), .kd(kd), .dt(dt), .done(div_done), .quot(div_q)
  );

  ipid_mul u_mul (
    .clk(clk), .start(mul_start), .coef(mul_coef), .opnd(mul_op),
    .done(mul_done), .prod(mul_p)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && in_ready) state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_IMUL;
      ST_IMUL:   if (mul_done) state_next = ST_COEF;
      ST_COEF:   state_next = ST_MAC0;
      ST_MAC0:   if (mul_done) state_next = ST_MAC1;
      ST_MAC1:   if (mul_done) state_next = ST_MAC2;
      ST_MAC2:   if (mul_done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE) && !cfg_valid;
    cfg_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    div_start = in_valid && in_ready;
    mul_start = ((state == ST_DIV) && div_done) || ((state == ST_COEF)) ||
                ((state == ST_MAC0 || state == ST_MAC1) && mul_done);
    case (state)
      ST_DIV: begin
        mul_coef = CoefW'(ki);
        mul_op   = {2'b00, dt_eff};
      end
      ST_COEF: begin
        mul_coef = ca;
        mul_op   = {e0[DataW-1], e0};
      end
      ST_MAC0: begin
        mul_coef = cb;
        mul_op   = {e1[DataW-1], e1};
      end
      default: begin
        mul_coef = cq;
        mul_op   = {e2[DataW-1], e2};
      end
    endcase
  end

  assign shifted = sum >>> FRAC_BITS;
  assign inc_clip = (shifted > AccW'(Max32)) || (shifted < $signed(AccW'(Min32)));
  assign inc32 = (shifted > AccW'(Max32)) ? Max32 :
                 (shifted < $signed(AccW'(Min32))) ? Min32 : shifted[DataW-1:0];
  assign dsum = {acc[DataW-1], acc} + {inc32[DataW-1], inc32};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kp <= '0; ki <= '0; kd <= '0;
      dt <= PeriodW'(1) << FRAC_BITS;
      e0 <= '0; e1 <= '0; e2 <= '0; acc <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegKp:   kp <= cfg_data;
          RegKi:   ki <= cfg_data;
          RegKd:   kd <= cfg_data;
          RegDt:   dt <= cfg_data[PeriodW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        e2 <= e1; e1 <= e0; e0 <= enew;
      end
      if (state == ST_FINISH) begin
        if (dsum > $signed({1'b0, Max32})) acc <= Max32;
        else if (dsum < $signed({1'b1, Min32})) acc <= Min32;
        else acc <= dsum[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) cq <= div_q;
    if (state == ST_IMUL && mul_done) iterm <= CoefW'(mul_p >>> (FRAC_BITS + 1));
    if (state == ST_COEF) begin
      sum <= '0;
    end
    if ((state == ST_MAC0 || state == ST_MAC1 || state == ST_MAC2) && mul_done)
      sum <= sum + mul_p;
    if (state == ST_FINISH) begin
      increment <= inc32;
      saturated <= inc_clip || (dsum > $signed({1'b0, Max32})) ||
                   (dsum < $signed({1'b1, Min32}));
      if (dsum > $signed({1'b0, Max32})) drive <= Max32;
      else if (dsum < $signed({1'b1, Min32})) drive <= Min32;
      else drive <= dsum[DataW-1:0];
    end
  end
endmodule

// ----- rtl/core/ipid_checker.sv -----
// ----------------------------------------------------------------------------
// ipid_checker
// Port-level checks of the incremental PID controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ipid_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic signed [31:0] drive
);
  `CHK_ALWAYS(a_no_overlap, rst, !(in_ready && out_valid), "input taken while result pending")
  `CHK_NEXT(a_accept_busy, rst, in_valid && in_ready, !in_ready, "ready stayed after accept")
  `CHK_NEXT(a_hold, rst, out_valid && !out_ready, out_valid && $stable(drive), "result dropped")
  `CHK_ALWAYS(a_cfg_idle, rst, !in_ready || cfg_ready, "config taken while busy")
endmodule

bind incremental_pid_controller ipid_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready), .drive(drive)
);
